FILE: sv/cssl_pkg.sv
// Shared types, constants and helpers of the cascaded stereo slew limiter.
`default_nettype none
package cssl_pkg;

    localparam int STAGE_COUNT = 10;
    localparam int STAGE_W     = $clog2(STAGE_COUNT);
    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(STAGE_COUNT - 1);

    localparam int SAMPLE_W   = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALO    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_WET = 2'd3;

    localparam logic [23:0] RST_BASE    = 24'd4194304;
    localparam logic [3:0]  RST_FIRST   = 4'd5;
    localparam logic [16:0] RST_HALO    = 17'd0;
    localparam logic [16:0] RST_INV_WET = 17'd65536;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic signed [31:0] PHI_Q30    = 32'sd1737350766;
    localparam logic signed [31:0] INVPHI_Q30 = 32'sd663608942;
    localparam logic signed [31:0] K078_Q16   = 32'sd51118;

    // Multiplier operand and result widths.
    localparam int MUL_A_W = 34;
    localparam int MUL_C_W = 32;
    localparam int MUL_R_W = 34;

    typedef enum logic [3:0] {
        MS_D_INVPHI,
        MS_D_H,
        MS_T_OMH,
        MS_D_H78,
        MS_T_OMH78,
        MS_P_OMH,
        MS_H_K078,
        MS_S_WET,
        MS_DRY_DRY,
        MS_THR_PHI
    } t_mul_sel;

    typedef struct packed {
        logic               load_in;
        logic               thr_init;
        logic               thr_store;
        logic               mul_go;
        t_mul_sel           mul_sel;
        logic               st_load;
        logic               st_diff;
        logic               st_clamp_hi;
        logic               st_clamp_lo;
        logic               st_write;
        logic               mix_sum;
        logic               out_load;
        logic [STAGE_W-1:0] k;
        logic               ch;
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] first_stage;
    } t_dp_stat;

    // Saturate a wide signed value to the signed 32 bit range.
    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -37'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/cssl_datapath.sv
// Datapath: configuration, stage state, shared rounding multiplier and mixing.
`default_nettype none
module cssl_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [cssl_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [cssl_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic [2*cssl_pkg::SAMPLE_W-1:0]   i_s_tdata,
    input  wire cssl_pkg::t_dp_cmd                 i_cmd,
    output cssl_pkg::t_dp_stat                     o_stat,
    output logic [2*cssl_pkg::SAMPLE_W-1:0]        o_m_tdata
);

    localparam int SW = cssl_pkg::SAMPLE_W;
    localparam int NS = cssl_pkg::STAGE_COUNT;

    logic [23:0] r_base;
    logic [3:0]  r_first;
    logic [16:0] r_halo;
    logic [16:0] r_inv_wet;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= cssl_pkg::RST_BASE;
            r_first   <= cssl_pkg::RST_FIRST;
            r_halo    <= cssl_pkg::RST_HALO;
            r_inv_wet <= cssl_pkg::RST_INV_WET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                cssl_pkg::CFG_BASE:    r_base    <= i_cfg_wdata[23:0];
                cssl_pkg::CFG_FIRST:   r_first   <= i_cfg_wdata[3:0];
                cssl_pkg::CFG_HALO:    r_halo    <= i_cfg_wdata[16:0];
                cssl_pkg::CFG_INV_WET: r_inv_wet <= i_cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    assign o_stat.first_stage = r_first;

    logic [16:0]        h;
    logic [16:0]        w;
    logic [16:0]        omh;
    logic [16:0]        omh78;
    logic signed [18:0] wet;
    logic signed [18:0] dry_raw;
    logic signed [18:0] dry;

    // Per-item values and stage state.
    logic signed [31:0] r_samp [2];
    logic signed [31:0] r_dry_in [2];
    logic signed [31:0] r_prev [2][NS];
    logic signed [31:0] r_invs [2][NS];
    logic [31:0]        r_thr [NS];
    logic [32:0]        r_t_acc;
    logic [31:0]        t_sat;
    logic signed [31:0] r_s;
    logic signed [31:0] r_p;
    logic signed [31:0] r_inv;
    logic [31:0]        r_t;
    logic signed [32:0] r_d;
    logic [16:0]        r_h78;
    logic signed [cssl_pkg::MUL_R_W-1:0] r_m1, r_mdh, r_mth, r_mdh78, r_mth78, r_mpo;
    logic signed [cssl_pkg::MUL_R_W-1:0] r_mwet, r_mdry;
    logic signed [SW-1:0] r_mix [2];
    logic [2*SW-1:0]      r_out;

    always_comb begin
        h       = (r_halo > cssl_pkg::ONE_Q16) ? cssl_pkg::ONE_Q16 : r_halo;
        w       = (r_inv_wet > cssl_pkg::ONE_Q16) ? cssl_pkg::ONE_Q16 : r_inv_wet;
        omh     = cssl_pkg::ONE_Q16 - h;
        omh78   = cssl_pkg::ONE_Q16 - r_h78;
        wet     = $signed({1'b0, w, 1'b0}) - 19'sd65536;
        dry_raw = 19'sd131072 - $signed({1'b0, w, 1'b0});
        dry     = (dry_raw > 19'sd65536) ? 19'sd65536 : dry_raw;
        t_sat   = (r_t_acc > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r_t_acc[31:0];
    end

    // Shared multiplier: sign-magnitude product, rounded half away from zero.
    logic signed [cssl_pkg::MUL_A_W-1:0] mul_a;
    logic signed [cssl_pkg::MUL_C_W-1:0] mul_c;
    logic                                mul_sh30;
    logic [cssl_pkg::MUL_A_W-1:0]        mag_a;
    logic [cssl_pkg::MUL_C_W-1:0]        mag_c;

    always_comb begin
        mul_a    = '0;
        mul_c    = '0;
        mul_sh30 = 1'b0;
        case (i_cmd.mul_sel)
            cssl_pkg::MS_D_INVPHI: begin
                mul_a    = 34'(r_d);
                mul_c    = cssl_pkg::INVPHI_Q30;
                mul_sh30 = 1'b1;
            end
            cssl_pkg::MS_D_H: begin
                mul_a = 34'(r_d);
                mul_c = $signed({15'd0, h});
            end
            cssl_pkg::MS_T_OMH: begin
                mul_a = $signed({2'b00, r_t});
                mul_c = $signed({15'd0, omh});
            end
            cssl_pkg::MS_D_H78: begin
                mul_a = 34'(r_d);
                mul_c = $signed({15'd0, r_h78});
            end
            cssl_pkg::MS_T_OMH78: begin
                mul_a = $signed({2'b00, r_t});
                mul_c = $signed({15'd0, omh78});
            end
            cssl_pkg::MS_P_OMH: begin
                mul_a = 34'(r_p);
                mul_c = $signed({15'd0, omh});
            end
            cssl_pkg::MS_H_K078: begin
                mul_a = $signed({17'd0, h});
                mul_c = cssl_pkg::K078_Q16;
            end
            cssl_pkg::MS_S_WET: begin
                mul_a = 34'(r_samp[i_cmd.ch]);
                mul_c = 32'(wet);
            end
            cssl_pkg::MS_DRY_DRY: begin
                mul_a = 34'(r_dry_in[i_cmd.ch]);
                mul_c = 32'(dry);
            end
            cssl_pkg::MS_THR_PHI: begin
                mul_a    = $signed({2'b00, t_sat});
                mul_c    = cssl_pkg::PHI_Q30;
                mul_sh30 = 1'b1;
            end
            default: ;
        endcase
        mag_a = mul_a[cssl_pkg::MUL_A_W-1] ? 34'(-mul_a) : 34'(mul_a);
        mag_c = mul_c[cssl_pkg::MUL_C_W-1] ? 32'(-mul_c) : 32'(mul_c);
    end

    logic [65:0]        r_mprod;
    logic               r_mneg;
    logic               r_msh30;
    logic               r_mvalid;
    cssl_pkg::t_mul_sel r_msel;
    logic [65:0]        rnd_sum;
    logic [32:0]        rnd_mag;
    logic signed [cssl_pkg::MUL_R_W-1:0] mres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else begin
            r_mvalid <= i_cmd.mul_go;
        end
        r_mprod <= 66'(mag_a) * 66'(mag_c);
        r_mneg  <= mul_a[cssl_pkg::MUL_A_W-1] ^ mul_c[cssl_pkg::MUL_C_W-1];
        r_msh30 <= mul_sh30;
        r_msel  <= i_cmd.mul_sel;
    end

    always_comb begin
        if (r_msh30) begin
            rnd_sum = (r_mprod + 66'(1 << 29)) >> 30;
        end else begin
            rnd_sum = (r_mprod + 66'(1 << 15)) >> 16;
        end
        rnd_mag = rnd_sum[32:0];
        mres    = r_mneg ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});
    end

    // Stage arithmetic, kept 37 bits wide so that no intermediate wraps.
    logic signed [36:0] s37, p37, t37, pred, hi_val, lo_val;

    always_comb begin
        s37    = 37'(r_s);
        p37    = 37'(r_p);
        t37    = $signed({5'd0, r_t});
        pred   = s37 - p37 - 37'(r_m1);
        hi_val = p37 - 37'(r_mdh) + 37'(r_mth);
        lo_val = p37 - 37'(r_mdh78) - 37'(r_mth78);
    end

    // Wet/dry mix, rounded by 5 bits and saturated to the output range.
    logic signed [34:0] mix_sum;
    logic [34:0]        mix_mag;
    logic [29:0]        mix_rnd;
    logic signed [SW-1:0] mix_res;

    always_comb begin
        mix_sum = 35'(r_mwet) + 35'(r_mdry);
        mix_mag = mix_sum[34] ? 35'(-mix_sum) : 35'(mix_sum);
        mix_rnd = 30'((mix_mag + 35'd16) >> 5);
        if (!mix_sum[34]) begin
            mix_res = (mix_rnd > 30'd8388607) ? 24'sh7FFFFF : $signed(mix_rnd[23:0]);
        end else begin
            mix_res = (mix_rnd > 30'd8388608) ? 24'sh800000 : -$signed(mix_rnd[23:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                for (int k = 0; k < NS; k++) begin
                    r_prev[c][k] <= '0;
                    r_invs[c][k] <= '0;
                end
            end
        end else if (i_cmd.st_write) begin
            r_prev[i_cmd.ch][i_cmd.k] <= r_s;
            // The product magnitude never exceeds that of the previous sample.
            r_invs[i_cmd.ch][i_cmd.k] <= r_mpo[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mvalid) begin
            case (r_msel)
                cssl_pkg::MS_D_INVPHI: r_m1    <= mres;
                cssl_pkg::MS_D_H:      r_mdh   <= mres;
                cssl_pkg::MS_T_OMH:    r_mth   <= mres;
                cssl_pkg::MS_D_H78:    r_mdh78 <= mres;
                cssl_pkg::MS_T_OMH78:  r_mth78 <= mres;
                cssl_pkg::MS_P_OMH:    r_mpo   <= mres;
                cssl_pkg::MS_H_K078:   r_h78   <= mres[16:0];
                cssl_pkg::MS_S_WET:    r_mwet  <= mres;
                cssl_pkg::MS_DRY_DRY:  r_mdry  <= mres;
                cssl_pkg::MS_THR_PHI: begin
                    if (!i_cmd.thr_init) begin
                        r_t_acc <= mres[32:0];
                    end
                end
                default: ;
            endcase
        end
        // A restarted threshold setup discards a product still in flight.
        if (i_cmd.thr_init) begin
            r_t_acc <= {3'd0, r_base, 6'd0};
        end
        if (i_cmd.thr_store) begin
            r_thr[i_cmd.k] <= t_sat;
        end
        if (i_cmd.load_in) begin
            r_samp[0]   <= {{3{i_s_tdata[SW-1]}}, i_s_tdata[SW-1:0], 5'd0};
            r_samp[1]   <= {{3{i_s_tdata[2*SW-1]}}, i_s_tdata[2*SW-1:SW], 5'd0};
            r_dry_in[0] <= {{3{i_s_tdata[SW-1]}}, i_s_tdata[SW-1:0], 5'd0};
            r_dry_in[1] <= {{3{i_s_tdata[2*SW-1]}}, i_s_tdata[2*SW-1:SW], 5'd0};
        end else if (i_cmd.st_write) begin
            r_samp[i_cmd.ch] <= r_s;
        end
        if (i_cmd.st_load) begin
            r_s   <= r_samp[i_cmd.ch];
            r_p   <= r_prev[i_cmd.ch][i_cmd.k];
            r_inv <= r_invs[i_cmd.ch][i_cmd.k];
            r_t   <= r_thr[i_cmd.k];
        end else if (i_cmd.st_clamp_hi) begin
            if (pred > t37) begin
                r_s <= cssl_pkg::sat32(hi_val);
            end
        end else if (i_cmd.st_clamp_lo) begin
            if (-pred > t37) begin
                r_s <= cssl_pkg::sat32(lo_val);
            end
        end
        if (i_cmd.st_diff) begin
            r_d <= 33'(r_p) - 33'(r_inv);
        end
        if (i_cmd.mix_sum) begin
            r_mix[i_cmd.ch] <= mix_res;
        end
        if (i_cmd.out_load) begin
            r_out <= {r_mix[1], r_mix[0]};
        end
    end

    assign o_m_tdata = r_out;

endmodule
`default_nettype wire

FILE: sv/cssl_ctrl.sv
// Controller: sequences threshold setup, the stage cascade and the final mix.
`default_nettype none
module cssl_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_thr_restart,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    input  wire cssl_pkg::t_dp_stat i_stat,
    output cssl_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_THR   = 5'b00001,
        S_IDLE  = 5'b00010,
        S_STAGE = 5'b00100,
        S_MIX   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                       r_state, n_state;
    logic [3:0]                   r_step, n_step;
    logic [cssl_pkg::STAGE_W-1:0] r_k, n_k;
    logic                         r_ch, n_ch;
    logic                         r_out_valid, n_out_valid;
    logic                         accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_k     = r_k;
        n_ch    = r_ch;
        o_cmd   = '0;
        o_cmd.k  = r_k;
        o_cmd.ch = r_ch;
        case (r_state)
            S_THR: begin
                case (r_step)
                    4'd0: begin
                        o_cmd.thr_init = 1'b1;
                        n_k    = cssl_pkg::LAST_STAGE;
                        n_step = 4'd1;
                    end
                    4'd1: begin
                        o_cmd.thr_store = 1'b1;
                        if (r_k == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.mul_go  = 1'b1;
                            o_cmd.mul_sel = cssl_pkg::MS_THR_PHI;
                            n_step = 4'd2;
                        end
                    end
                    default: begin
                        n_k    = r_k - 1'b1;
                        n_step = 4'd1;
                    end
                endcase
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_in = 1'b1;
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.mul_sel = cssl_pkg::MS_H_K078;
                    n_step = 4'd0;
                    n_ch   = 1'b0;
                    if (i_stat.first_stage > 4'(cssl_pkg::LAST_STAGE)) begin
                        n_state = S_MIX;
                    end else begin
                        n_state = S_STAGE;
                        n_k     = i_stat.first_stage[cssl_pkg::STAGE_W-1:0];
                    end
                end
            end
            S_STAGE: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    4'd0: o_cmd.st_load = 1'b1;
                    4'd1: o_cmd.st_diff = 1'b1;
                    4'd2: begin
                        o_cmd.mul_go  = 1'b1;
                        o_cmd.mul_sel = cssl_pkg::MS_D_INVPHI;
                    end
                    4'd3: begin
                        o_cmd.mul_go  = 1'b1;
                        o_cmd.mul_sel = cssl_pkg::MS_D_H;
                    end
                    4'd4: begin
                        o_cmd.mul_go  = 1'b1;
                        o_cmd.mul_sel = cssl_pkg::MS_T_OMH;
                    end
                    4'd5: begin
                        o_cmd.mul_go  = 1'b1;
                        o_cmd.mul_sel = cssl_pkg::MS_D_H78;
                    end
                    4'd6: begin
                        o_cmd.mul_go  = 1'b1;
                        o_cmd.mul_sel = cssl_pkg::MS_T_OMH78;
                    end
                    4'd7: begin
                        o_cmd.mul_go      = 1'b1;
                        o_cmd.mul_sel     = cssl_pkg::MS_P_OMH;
                        o_cmd.st_clamp_hi = 1'b1;
                    end
                    4'd8: o_cmd.st_clamp_lo = 1'b1;
                    default: begin
                        o_cmd.st_write = 1'b1;
                        n_step = 4'd0;
                        if (!r_ch) begin
                            n_ch = 1'b1;
                        end else begin
                            n_ch = 1'b0;
                            if (r_k == cssl_pkg::LAST_STAGE) begin
                                n_state = S_MIX;
                            end else begin
                                n_k = r_k + 1'b1;
                            end
                        end
                    end
                endcase
            end
            S_MIX: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    4'd0: begin
                        o_cmd.mul_go  = 1'b1;
                        o_cmd.mul_sel = cssl_pkg::MS_S_WET;
                    end
                    4'd1: begin
                        o_cmd.mul_go  = 1'b1;
                        o_cmd.mul_sel = cssl_pkg::MS_DRY_DRY;
                    end
                    4'd2: ;
                    default: begin
                        o_cmd.mix_sum = 1'b1;
                        n_step = 4'd0;
                        if (!r_ch) begin
                            n_ch = 1'b1;
                        end else begin
                            n_ch    = 1'b0;
                            n_state = S_DONE;
                        end
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_THR;
        endcase
        if (i_thr_restart) begin
            n_state = S_THR;
            n_step  = 4'd0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_THR;
            r_step      <= 4'd0;
            r_k         <= '0;
            r_ch        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_k         <= n_k;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
        end
    end

    a_out_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("result register loaded but valid not raised");

    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STAGE) |-> (r_k <= cssl_pkg::LAST_STAGE)
            && (4'(r_k) >= i_stat.first_stage))
        else $error("stage index outside the active range");

    a_thr_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_thr_restart |=> (r_state == S_THR) && (r_step == 4'd0))
        else $error("threshold setup did not restart");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> (r_state == S_STAGE) || (r_state == S_MIX))
        else $error("accepted item did not start processing");

endmodule
`default_nettype wire

FILE: sv/cascaded_stereo_slew_limiter_core.sv
// Cascaded stereo slew limiter top level.
`default_nettype none
// Each stereo pair runs through the active stages (first_stage through nine),
// left then right per stage, on one shared rounding multiplier. The input is
// taken only while the block is idle; one finished result can wait in the
// output register while the next item is accepted. After reset, and after
// every write to base_threshold, the stage thresholds are rebuilt, during
// which no transaction is taken on the input.
module cascaded_stereo_slew_limiter_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [cssl_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [cssl_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // left_sample [23:0], right_sample [47:24]
    input  wire logic [2*cssl_pkg::SAMPLE_W-1:0]   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // left_result [23:0], right_result [47:24]
    output logic [2*cssl_pkg::SAMPLE_W-1:0]        m_axis_tdata
);

    cssl_pkg::t_dp_cmd  cmd;
    cssl_pkg::t_dp_stat stat;
    logic               thr_restart;

    assign thr_restart = i_cfg_we && (i_cfg_addr == cssl_pkg::CFG_BASE);

    cssl_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_thr_restart (thr_restart),
        .i_s_tvalid    (s_axis_tvalid),
        .o_s_tready    (s_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    cssl_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Testbench of the cascaded stereo slew limiter: random streams checked against a predictor.
`default_nettype none

class slew_scoreboard;
    localparam longint PHI = 1737350766;
    localparam longint INVPHI = 663608942;
    localparam longint K078 = 51118;
    localparam longint ONE = 65536;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    logic [23:0] base_thr;
    logic [3:0]  first_stage;
    logic [16:0] halo;
    logic [16:0] inv_wet;
    longint prev_l[10], prev_r[10], inv_l[10], inv_r[10], thr[10];
    logic [47:0] pending[$];
    int errors;

    function new();
        errors = 0;
        base_thr = cssl_pkg::RST_BASE;
        first_stage = cssl_pkg::RST_FIRST;
        halo = cssl_pkg::RST_HALO;
        inv_wet = cssl_pkg::RST_INV_WET;
        for (int k = 0; k < 10; k++) begin
            prev_l[k] = 0; prev_r[k] = 0; inv_l[k] = 0; inv_r[k] = 0;
        end
        build_thresholds();
    endfunction

    // Product shifted right, rounded to nearest with halves away from zero.
    function longint round_mul(longint a, longint c, int sh);
        bit neg;
        longint unsigned ma, mc, r;
        neg = (a < 0) != (c < 0);
        ma = a < 0 ? -a : a;
        mc = c < 0 ? -c : c;
        r = (ma * mc + ((64'd1 << sh) >> 1)) >> sh;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function longint clip32(longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    function void build_thresholds();
        longint unsigned t;
        t = longint'(base_thr) << 6;
        for (int k = 9; k >= 0; k--) begin
            if (t > QMAX) t = QMAX;
            thr[k] = t;
            t = (t * PHI + (64'd1 << 29)) >> 30;
        end
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] val);
        case (idx)
            cssl_pkg::CFG_BASE: begin
                base_thr = val;
                build_thresholds();
            end
            cssl_pkg::CFG_FIRST: first_stage = val[3:0];
            cssl_pkg::CFG_HALO: halo = val[16:0];
            cssl_pkg::CFG_INV_WET: inv_wet = val[16:0];
            default: ;
        endcase
    endfunction

    function longint limit_stage(longint s, ref longint prev, ref longint inv, input longint t,
                                 input longint h);
        longint p, d, h78, slope;
        p = prev;
        d = p - inv;
        h78 = round_mul(h, K078, 16);
        slope = (s - p) - round_mul(d, INVPHI, 30);
        if (slope > t)
            s = clip32((p - round_mul(d, h, 16)) + round_mul(t, ONE - h, 16));
        slope = (s - p) - round_mul(d, INVPHI, 30);
        if (-slope > t)
            s = clip32((p - round_mul(d, h78, 16)) - round_mul(t, ONE - h78, 16));
        inv = clip32(round_mul(p, ONE - h, 16));
        prev = s;
        return s;
    endfunction

    function logic [23:0] mix_out(longint ws, longint ds, longint wet, longint dry);
        longint m, r;
        m = round_mul(ws, wet, 16) + round_mul(ds, dry, 16);
        r = round_mul(m, 1, 5);
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r[23:0];
    endfunction

    function void note_input(logic [47:0] pair);
        longint h, w, wet, dry, dl, dr, sl, sr;
        h = halo > ONE ? ONE : longint'(halo);
        w = inv_wet > ONE ? ONE : longint'(inv_wet);
        wet = 2 * w - ONE;
        dry = 2 * ONE - 2 * w;
        if (dry > ONE) dry = ONE;
        dl = longint'($signed(pair[23:0])) * 32;
        dr = longint'($signed(pair[47:24])) * 32;
        sl = dl;
        sr = dr;
        for (int k = first_stage; k < 10; k++) begin
            sl = limit_stage(sl, prev_l[k], inv_l[k], thr[k], h);
            sr = limit_stage(sr, prev_r[k], inv_r[k], thr[k], h);
        end
        pending.push_back({mix_out(sr, dr, wet, dry), mix_out(sl, dl, wet, dry)});
    endfunction

    function void check_result(logic [47:0] got);
        logic [47:0] want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got[23:0] !== want[23:0]) begin
            $display("%0t: left_result expected %h actual %h", $time, want[23:0], got[23:0]);
            errors++;
        end
        if (got[47:24] !== want[47:24]) begin
            $display("%0t: right_result expected %h actual %h", $time, want[47:24],
                     got[47:24]);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_addr = '0;
    logic [23:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 0;
    wire         s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 0;
    wire  [47:0] m_axis_tdata;

    slew_scoreboard board = new();
    bit sending_done = 0;
    int hold_off = 0;
    int rx_wait = 0;
    int rx_draw = 0;

    cascaded_stereo_slew_limiter_core dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        #200ms;
        $display("FAILURE");
        $finish;
    end

    // The caller drops the write enable after its last write.
    task automatic write_cfg(logic [1:0] idx, logic [23:0] val);
        i_cfg_we <= 1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        board.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Valid stays high after a transaction until the next gap or the next drain.
    task automatic send_pair(logic [23:0] l, logic [23:0] r);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {r, l};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_input({r, l});
    endtask

    // Let the pipeline drain before touching a register.
    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_sample(int mode);
        case (mode)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 255) - 128);
            default: return 24'($urandom());
        endcase
    endfunction

    // Receiver: a random wait drawn per transaction, plus a single long hold-off.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_draw = $urandom_range(0, 12);
            rx_wait <= rx_draw;
            m_axis_tready <= (rx_draw == 0);
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_axis_tready <= (rx_wait == 1);
        end else begin
            m_axis_tready <= 1;
        end
    end

    initial begin
        logic [23:0] bases[5];
        logic [3:0] firsts[5];
        logic [16:0] halos[5];
        logic [16:0] wets[5];
        bases = '{24'd4194304, 24'd0, 24'hFFFFFF, 24'd20000, 24'd900000};
        firsts = '{4'd5, 4'd0, 4'd9, 4'd15, 4'd7};
        halos = '{17'd0, 17'd65536, 17'h1FFFF, 17'd30000, 17'd12345};
        wets = '{17'd65536, 17'd0, 17'd32768, 17'h1FFFF, 17'd50000};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (30) @(posedge i_clk);
        // Directed extremes at the reset setting.
        send_pair(24'h7FFFFF, 24'h800000);
        send_pair(24'h800000, 24'h7FFFFF);
        send_pair(24'h000000, 24'h000000);
        send_pair(24'hFFFFFF, 24'h000001);
        send_pair(24'h7FFFFF, 24'h7FFFFF);
        send_pair(24'h800000, 24'h800000);
        hold_off = 1500;
        for (int i = 0; i < 6; i++) send_pair(rand_sample(i % 4), rand_sample(3));
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            write_cfg(cssl_pkg::CFG_BASE, ph == 4 ? 24'($urandom()) : bases[ph]);
            write_cfg(cssl_pkg::CFG_FIRST, 24'(firsts[ph]));
            write_cfg(cssl_pkg::CFG_HALO,
                      ph == 4 ? 24'($urandom_range(0, 131071)) : 24'(halos[ph]));
            write_cfg(cssl_pkg::CFG_INV_WET, 24'(wets[ph]));
            i_cfg_we <= 0;
            repeat (30) @(posedge i_clk);
            for (int i = 0; i < 306; i++) begin
                if (i % 40 < 3) send_pair(rand_sample(i % 2), rand_sample((i + 1) % 2));
                else send_pair(rand_sample($urandom_range(2, 3)),
                               rand_sample($urandom_range(2, 3)));
            end
        end
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule

`default_nettype wire

FILE: cascaded_stereo_slew_limiter_core.f
sv/cssl_pkg.sv
sv/cssl_datapath.sv
sv/cssl_ctrl.sv
sv/cascaded_stereo_slew_limiter_core.sv
test/testbench.sv
